// File: rtl/core/evs_pkg.sv
// Shared types, widths and constants of the energy VAD speech segmenter.
package evs_pkg;

	// Samples per analysis frame.
	localparam int FRAME_LEN = 1024;

	// Field and state widths.
	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = 41;
	localparam int THR_W    = 15;
	localparam int CNT_W    = 24;
	localparam int FPOS_W   = $clog2(FRAME_LEN);
	localparam int LIM_W    = 2 * THR_W + FPOS_W + 1;
	localparam int CMP_W    = (LIM_W > SUM_W) ? LIM_W : SUM_W;

	// Configuration port geometry.
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register reset values.
	localparam logic            VAD_MODE_RST = 1'b1;
	localparam logic [THR_W-1:0] THR_RST     = THR_W'(328);
	localparam logic [CNT_W-1:0] SIL_LIM_RST = CNT_W'(48000);
	localparam logic [CNT_W-1:0] MIN_SPE_RST = CNT_W'(24000);
	localparam logic [2*THR_W-1:0] THR_SQ_RST = (2*THR_W)'(328 * 328);
	localparam logic [LIM_W-1:0] THR_LIM_RST  = LIM_W'(64'd328 * 64'd328 * FRAME_LEN);

	// Saturation limits.
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_VAD_MODE = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_SIL_LIMIT = 2'd2,
		REG_MIN_SPEECH = 2'd3
	} evs_reg_t;

	// Segment event codes carried on the result tuser.
	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_SEND = 2'd1,
		EV_DISCARD = 2'd2
	} evs_event_t;

	// Frame-end handoff from the energy pipe to the segmenter.
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} evs_frame_t;

endpackage

// File: rtl/core/evs_frame_energy.sv
// Per-sample squaring and frame sum-of-squares accumulation pipe.
module evs_frame_energy (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [evs_pkg::SAMPLE_W-1:0] in_sample,
	output evs_pkg::evs_frame_t               frame,
	input  logic                              frame_ready
);

	logic [evs_pkg::FPOS_W-1:0]   fpos_q;
	logic                         valid_s1;
	logic                         last_s1;
	logic [evs_pkg::SAMPLE_W-1:0] sample_s1;
	logic                         valid_s2;
	logic                         last_s2;
	logic [evs_pkg::SQ_W-1:0]     sq_s2;
	logic [evs_pkg::SUM_W-1:0]    sum_q;
	logic                         valid_s3;
	logic [evs_pkg::SUM_W-1:0]    sum_s3;

	logic                         s3_free;
	logic                         s2_go;
	logic                         s2_free;
	logic                         s1_go;
	logic                         in_fire;
	logic                         fpos_last;
	logic [evs_pkg::MAG_W-1:0]    mag;
	logic [2*evs_pkg::MAG_W-1:0]  sq_full;
	logic [evs_pkg::SUM_W:0]      sum_add;
	logic [evs_pkg::SUM_W-1:0]    sum_sat;

	// Stage readiness: only frame-end beats need room in the last stage.
	assign s3_free  = !valid_s3 || frame_ready;
	assign s2_go    = valid_s2 && (!last_s2 || s3_free);
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s1_go;
	assign in_fire  = in_valid && in_ready;

	assign fpos_last = (fpos_q == evs_pkg::FPOS_W'(evs_pkg::FRAME_LEN - 1));

	// Magnitude and square of the registered sample.
	assign mag     = sample_s1[evs_pkg::SAMPLE_W-1] ? (~sample_s1 + 1'b1) : sample_s1;
	assign sq_full = mag * mag;

	// Saturating accumulate of the square reaching the end of stage two.
	assign sum_add = {1'b0, sum_q} + (evs_pkg::SUM_W+1)'(sq_s2);
	assign sum_sat = sum_add[evs_pkg::SUM_W] ? evs_pkg::SUM_MAX : sum_add[evs_pkg::SUM_W-1:0];

	// Frame position counts accepted beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fpos_q <= '0;
		end else if (in_fire) begin
			fpos_q <= fpos_last ? '0 : fpos_q + 1'b1;
		end
	end

	// Stage one: the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_sample;
			last_s1   <= fpos_last;
		end
	end

	// Stage two: the registered square.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sq_s2   <= sq_full[evs_pkg::SQ_W-1:0];
			last_s2 <= last_s1;
		end
	end

	// Running frame sum, cleared when the frame-end beat passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (s2_go) begin
			sum_q <= last_s2 ? '0 : sum_sat;
		end
	end

	// Stage three: the finished frame sum waits here for the segmenter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= s2_go && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && last_s2) begin
			sum_s3 <= sum_sat;
		end
	end

	assign frame.valid = valid_s3;
	assign frame.sum   = sum_s3;

endmodule

// File: rtl/core/energy_vad_speech_segmenter.sv
// Top level of the energy VAD speech segmenter: registers, segment logic, result register.
//
//   channel   direction  beat contents
//   s_axis    in         tdata[15:0] sample (signed Q15)
//   m_axis    out        tdata: is_speech, frame_kept, segment_length; tuser: segment_event
//   apb       in/out     four registers at byte addresses 0, 4, 8, 12
//
// One sample beat is taken every cycle while the sample side is not stopped. Each frame of
// FRAME_LEN samples gives one result beat, registered in turn as square, frame sum and result.
// The frame-end beat waits in the frame sum stage while a result is still held, and the
// sample side stops only when that stage and the stages behind it are full.
// Reset is asynchronous and clears all counts and restores the register defaults.
module energy_vad_speech_segmenter (
	input  logic                        clk,
	input  logic                        arst_n,
	// Sample stream.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,  // [15:0] sample
	// Result stream.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // [0] is_speech, [1] frame_kept,
	                                                   // [25:2] segment_length, [31:26] zero
	output logic [1:0]                  m_axis_tuser,  // [1:0] segment_event
	// Register port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [evs_pkg::ADDR_W-1:0]  paddr,
	input  logic [evs_pkg::DATA_W-1:0]  pwdata,
	output logic [evs_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	logic                          vad_mode_q;
	logic [evs_pkg::THR_W-1:0]     thr_q;
	logic [evs_pkg::CNT_W-1:0]     sil_limit_q;
	logic [evs_pkg::CNT_W-1:0]     min_speech_q;
	logic [2*evs_pkg::THR_W-1:0]   thr_sq_q;
	logic [evs_pkg::LIM_W-1:0]     thr_lim_q;

	logic [evs_pkg::CNT_W-1:0]     cap_q;
	logic [evs_pkg::CNT_W-1:0]     sil_q;

	logic                          out_valid_q;
	logic                          speech_q;
	logic                          kept_q;
	evs_pkg::evs_event_t           event_q;
	logic [evs_pkg::CNT_W-1:0]     seglen_q;

	evs_pkg::evs_frame_t           frame;
	logic                          frame_ready;
	logic                          frame_fire;
	logic                          wr_en;
	evs_pkg::evs_reg_t             reg_sel;

	logic                          speech;
	logic [evs_pkg::CNT_W:0]       cap_add;
	logic [evs_pkg::CNT_W:0]       sil_add;
	logic [evs_pkg::CNT_W-1:0]     cap_inc;
	logic [evs_pkg::CNT_W-1:0]     sil_inc;
	logic                          kept_n;
	evs_pkg::evs_event_t           event_n;
	logic [evs_pkg::CNT_W-1:0]     seglen_n;
	logic [evs_pkg::CNT_W-1:0]     cap_n;
	logic [evs_pkg::CNT_W-1:0]     sil_n;

	// Squaring and accumulation pipe.
	evs_frame_energy u_energy (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata),
		.frame       (frame),
		.frame_ready (frame_ready)
	);

	// Register port decode.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = evs_pkg::evs_reg_t'(paddr[evs_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vad_mode_q   <= evs_pkg::VAD_MODE_RST;
			thr_q        <= evs_pkg::THR_RST;
			sil_limit_q  <= evs_pkg::SIL_LIM_RST;
			min_speech_q <= evs_pkg::MIN_SPE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				evs_pkg::REG_VAD_MODE:   vad_mode_q   <= pwdata[0];
				evs_pkg::REG_THRESHOLD:  thr_q        <= pwdata[evs_pkg::THR_W-1:0];
				evs_pkg::REG_SIL_LIMIT:  sil_limit_q  <= pwdata[evs_pkg::CNT_W-1:0];
				evs_pkg::REG_MIN_SPEECH: min_speech_q <= pwdata[evs_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (reg_sel)
			evs_pkg::REG_VAD_MODE:   prdata = evs_pkg::DATA_W'(vad_mode_q);
			evs_pkg::REG_THRESHOLD:  prdata = evs_pkg::DATA_W'(thr_q);
			evs_pkg::REG_SIL_LIMIT:  prdata = evs_pkg::DATA_W'(sil_limit_q);
			evs_pkg::REG_MIN_SPEECH: prdata = evs_pkg::DATA_W'(min_speech_q);
			default:                 prdata = '0;
		endcase
	end

	// Speech limit: threshold squared times the frame length, built through the squared-threshold and limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q  <= evs_pkg::THR_SQ_RST;
			thr_lim_q <= evs_pkg::THR_LIM_RST;
		end else begin
			thr_sq_q  <= thr_q * thr_q;
			thr_lim_q <= evs_pkg::LIM_W'(thr_sq_q) * evs_pkg::LIM_W'(evs_pkg::FRAME_LEN);
		end
	end

	// The frame-end beat moves on when the result register is free or draining.
	assign frame_ready = !out_valid_q || m_axis_tready;
	assign frame_fire  = frame.valid && frame_ready;

	// Frame classification.
	assign speech = !vad_mode_q ||
		(evs_pkg::CMP_W'(frame.sum) >= evs_pkg::CMP_W'(thr_lim_q));

	// Saturating count increments.
	assign cap_add = {1'b0, cap_q} + (evs_pkg::CNT_W+1)'(evs_pkg::FRAME_LEN);
	assign sil_add = {1'b0, sil_q} + (evs_pkg::CNT_W+1)'(evs_pkg::FRAME_LEN);
	assign cap_inc = cap_add[evs_pkg::CNT_W] ? evs_pkg::CNT_MAX : cap_add[evs_pkg::CNT_W-1:0];
	assign sil_inc = sil_add[evs_pkg::CNT_W] ? evs_pkg::CNT_MAX : sil_add[evs_pkg::CNT_W-1:0];

	// Capture and endpoint decision for one frame.
	always_comb begin
		kept_n   = 1'b0;
		event_n  = evs_pkg::EV_NONE;
		seglen_n = '0;
		cap_n    = cap_q;
		sil_n    = sil_q;
		if (speech) begin
			kept_n = 1'b1;
			cap_n  = cap_inc;
			sil_n  = '0;
		end else if (cap_q != '0) begin
			kept_n = 1'b1;
			cap_n  = cap_inc;
			sil_n  = sil_inc;
			// Enough trailing silence closes the segment.
			if (sil_inc >= sil_limit_q) begin
				event_n  = (cap_inc >= min_speech_q) ? evs_pkg::EV_SEND : evs_pkg::EV_DISCARD;
				seglen_n = cap_inc;
				cap_n    = '0;
				sil_n    = '0;
			end
		end
	end

	// Capture counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			sil_q <= '0;
		end else if (frame_fire) begin
			cap_q <= cap_n;
			sil_q <= sil_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_ready) begin
			out_valid_q <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_fire) begin
			speech_q <= speech;
			kept_q   <= kept_n;
			event_q  <= event_n;
			seglen_q <= seglen_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, seglen_q, kept_q, speech_q};
	assign m_axis_tuser  = event_q;

endmodule

// File: rtl/core/evs_checker.sv
// Port-level checks of the energy VAD speech segmenter and their binding.
module evs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result beat holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// A segment closes only on a quiet frame that was kept.
	a_close_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != evs_pkg::EV_NONE) |->
			!m_axis_tdata[0] && m_axis_tdata[1])
		else $error("segment closed on a speech or dropped frame");

	// Segment length is reported only with a segment event, and never exceeds zero otherwise.
	a_len_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == evs_pkg::EV_NONE) |->
			(m_axis_tdata[25:2] == 24'd0))
		else $error("segment length without a segment event");

	// A closed segment always reports a nonzero length, and its unused tdata bits are zero.
	a_len_closed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == evs_pkg::EV_SEND ||
			m_axis_tuser == evs_pkg::EV_DISCARD) |->
			(m_axis_tdata[25:2] != 24'd0) && (m_axis_tdata[31:26] == 6'd0))
		else $error("closed segment with empty length or stray bits");

endmodule

bind energy_vad_speech_segmenter evs_checker u_evs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
